// ===== hdl/config_line_tokenizer_macros.svh =====
// assertion macros shared by the tokenizer modules
// no dependencies; included by the files that carry assertions
`ifndef CONFIG_LINE_TOKENIZER_MACROS_SVH
`define CONFIG_LINE_TOKENIZER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define CLT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be seen outside reset
`define CLT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CLT_ASSERT(lbl, clk, rstn, prop, msg)
`define CLT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== hdl/clt_pkg.sv =====
// shared types, constants and helper functions of the config line tokenizer
// no dependencies; imported by every tokenizer module but clt_ram
package clt_pkg;

    localparam int MAX_TOKEN  = 32;
    localparam int SET_SLOTS  = 4;
    localparam int SET_W      = 32;
    localparam int LEN_W      = $clog2(MAX_TOKEN + 1);
    localparam int IDX_W      = $clog2(MAX_TOKEN);
    localparam int FIFO_DEPTH = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int USER_W     = 3;

    localparam logic [SET_W-1:0] LIMITER_RESET   = 32'd61;
    localparam logic [SET_W-1:0] SEPARATOR_RESET = 32'd44;
    localparam logic [SET_W-1:0] COMMENT_RESET   = 32'd35;
    localparam logic [SET_W-1:0] QUOTE_RESET     = 32'd34;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMITER   = 2'd0,
        CFG_SEPARATOR = 2'd1,
        CFG_COMMENT   = 2'd2,
        CFG_QUOTE     = 2'd3
    } t_cfg_idx;

    // one flush request from the front to the back; len zero means bare line marker
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             lower;
        logic             cut;
        logic             line_end;
    } t_flush_cmd;

    // output sideband, byte_valid in the lowest bit
    typedef struct packed {
        logic truncated;
        logic token_last;
        logic byte_valid;
    } t_out_user;

    function automatic logic in_set(input logic [SET_W-1:0] set, input logic [7:0] b);
        logic [8*8-1:0] s;
        logic           hit;
        s   = 64'(set);
        hit = 1'b0;
        for (int k = 0; k < SET_SLOTS; k++) begin
            if (s[8*k +: 8] == b) begin
                hit = 1'b1;
            end
        end
        return hit && (b != CH_NUL);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            return b + CASE_DELTA;
        end
        return b;
    endfunction

endpackage

// ===== hdl/clt_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module clt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/clt_cmd_fifo.sv =====
// short queue of flush requests between the classifier front and the emitter back
// depends on clt_pkg and config_line_tokenizer_macros.svh
`include "config_line_tokenizer_macros.svh"

module clt_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  clt_pkg::t_flush_cmd i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output clt_pkg::t_flush_cmd o_cmd,
    output logic                o_empty
);
    import clt_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_flush_cmd       r_slot [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_slot[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));

    `CLT_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop, "flush queue overflow")
    `CLT_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "flush queue underflow")

endmodule

// ===== hdl/clt_front.sv =====
// front end: config registers, byte classification, line state and token store writes
// depends on clt_pkg; issues flush requests into clt_cmd_fifo
module clt_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [clt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [clt_pkg::SET_W-1:0]       i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,
    input  logic                            i_s_tlast,
    input  logic                            i_busy,
    output logic                            o_push,
    output clt_pkg::t_flush_cmd             o_cmd,
    output logic                            o_ram_we,
    output logic [clt_pkg::IDX_W-1:0]       o_ram_waddr,
    output logic [7:0]                      o_ram_wdata
);
    import clt_pkg::*;

    logic [SET_W-1:0] r_limiter, r_separator, r_comment, r_quote_set;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_cut, n_cut;
    logic             r_in_quote, n_in_quote;
    logic             r_lim_seen, n_lim_seen;
    logic             r_finished, n_finished;

    logic accept;
    logic is_com, is_lim, is_sep, is_quo, is_ws;
    logic act_flush, act_lower, append;

    assign accept = i_s_tvalid && o_s_tready;
    // store is shared with the back, so hold input while any flush is pending
    assign o_s_tready = !i_busy;

    assign is_com = in_set(r_comment, i_s_tdata);
    assign is_lim = in_set(r_limiter, i_s_tdata);
    assign is_sep = in_set(r_separator, i_s_tdata);
    assign is_quo = in_set(r_quote_set, i_s_tdata);
    assign is_ws  = (i_s_tdata == CH_SPACE) || (i_s_tdata == CH_TAB);

    always_comb begin
        n_len      = r_len;
        n_cut      = r_cut;
        n_in_quote = r_in_quote;
        n_lim_seen = r_lim_seen;
        n_finished = r_finished;
        act_flush  = 1'b0;
        act_lower  = 1'b0;
        append     = 1'b0;
        if (!r_finished) begin
            if (is_com) begin
                act_flush  = 1'b1;
                n_finished = 1'b1;
            end else if (is_lim && !r_lim_seen) begin
                if (r_len != '0) begin
                    act_flush  = 1'b1;
                    act_lower  = 1'b1;
                    n_lim_seen = 1'b1;
                end else begin
                    n_finished = 1'b1;
                end
            end else if (is_sep && !r_in_quote) begin
                act_flush = 1'b1;
            end else if (is_quo) begin
                act_flush  = 1'b1;
                n_in_quote = !r_in_quote;
            end else if (is_ws && !r_in_quote) begin
                // unquoted blank, dropped
            end else if (r_len < LEN_W'(MAX_TOKEN)) begin
                append = 1'b1;
                n_len  = r_len + 1'b1;
            end else begin
                n_cut = 1'b1;
            end
        end

        // a byte flushes at most one nonempty token: the byte's own flush
        // empties the token before the line end flush
        o_cmd.len      = act_flush ? r_len : n_len;
        o_cmd.cut      = act_flush ? r_cut : n_cut;
        o_cmd.lower    = act_lower;
        o_cmd.line_end = i_s_tlast;

        if (act_flush || i_s_tlast) begin
            n_len = '0;
            n_cut = 1'b0;
        end
        if (i_s_tlast) begin
            n_in_quote = 1'b0;
            n_lim_seen = 1'b0;
            n_finished = 1'b0;
        end
    end

    assign o_push      = accept && (i_s_tlast || (act_flush && r_len != '0));
    assign o_ram_we    = accept && append;
    assign o_ram_waddr = r_len[IDX_W-1:0];
    assign o_ram_wdata = i_s_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_cut      <= 1'b0;
            r_in_quote <= 1'b0;
            r_lim_seen <= 1'b0;
            r_finished <= 1'b0;
        end else if (accept) begin
            r_len      <= n_len;
            r_cut      <= n_cut;
            r_in_quote <= n_in_quote;
            r_lim_seen <= n_lim_seen;
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limiter   <= LIMITER_RESET;
            r_separator <= SEPARATOR_RESET;
            r_comment   <= COMMENT_RESET;
            r_quote_set <= QUOTE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LIMITER:   r_limiter   <= i_cfg_data;
                CFG_SEPARATOR: r_separator <= i_cfg_data;
                CFG_COMMENT:   r_comment   <= i_cfg_data;
                CFG_QUOTE:     r_quote_set <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/clt_back.sv =====
// back end: takes flush requests, reads the token store, drives the output register
// depends on clt_pkg and config_line_tokenizer_macros.svh
`include "config_line_tokenizer_macros.svh"

module clt_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fifo_empty,
    input  clt_pkg::t_flush_cmd           i_cmd,
    output logic                          o_pop,
    output logic                          o_busy,
    output logic                          o_ram_re,
    output logic [clt_pkg::IDX_W-1:0]     o_ram_raddr,
    input  logic [7:0]                    i_ram_rdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,
    output logic [clt_pkg::USER_W-1:0]    o_m_tuser,
    output logic                          o_m_tlast
);
    import clt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_back_state;

    t_back_state      r_state, n_state;
    t_flush_cmd       r_cmd, n_cmd;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic             r_ovalid;
    logic [7:0]       r_odata, n_odata;
    t_out_user        r_ouser, n_ouser;
    logic             r_olast, n_olast;

    logic out_free;
    logic load;
    logic is_last;

    assign out_free = !r_ovalid || i_m_tready;
    assign is_last  = (LEN_W'(r_idx) + LEN_W'(1)) == r_cmd.len;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        n_olast  = r_olast;
        o_pop    = 1'b0;
        o_ram_re = 1'b0;
        load     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_fifo_empty) begin
                    if (i_cmd.len == '0) begin
                        // bare line marker
                        if (out_free) begin
                            o_pop   = 1'b1;
                            load    = 1'b1;
                            n_odata = CH_NUL;
                            n_ouser = '0;
                            n_olast = 1'b1;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_cmd   = i_cmd;
                        n_idx   = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_ram_re = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    load               = 1'b1;
                    n_odata            = r_cmd.lower ? to_lower(i_ram_rdata) : i_ram_rdata;
                    n_ouser.byte_valid = 1'b1;
                    n_ouser.token_last = is_last;
                    n_ouser.truncated  = r_cmd.cut;
                    n_olast            = is_last && r_cmd.line_end;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_idx   <= n_idx;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
        r_olast <= n_olast;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_ram_raddr = r_idx;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ouser;
    assign o_m_tlast   = r_olast;

    `CLT_ASSERT(a_marker_ends_line, i_clk, i_rst_n, (o_m_tvalid && !o_m_tuser[0]) |-> o_m_tlast, "bare marker without line end")
    `CLT_ASSERT(a_read_then_load, i_clk, i_rst_n, (r_state == S_READ) |=> (r_state == S_LOAD), "store read not followed by load")

endmodule

// ===== hdl/config_line_tokenizer.sv =====
// A byte that closes a token pushes a flush request; the back pops it and, for each token
// byte, does a registered store read (S_READ), then loads the output register (S_LOAD).
// Throughput: 1 byte per cycle while a token fills and no flush is pending; a flush
// holds the input until the back is idle, as the next token reuses the store entries.
// Reset: synchronous, active low; clears line state and restores the default sets.
// The token store is not cleared; entries are only read after they are written.
module config_line_tokenizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [clt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [clt_pkg::SET_W-1:0]       i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,    // line_byte
    input  logic                            i_s_tlast,    // line_end
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [7:0]                      o_m_tdata,    // token_byte
    output logic [clt_pkg::USER_W-1:0]      o_m_tuser,    // byte_valid, token_last, token_truncated
    output logic                            o_m_tlast     // line_last
);
    import clt_pkg::*;

    t_flush_cmd       push_cmd, pop_cmd;
    logic             push, pop, fifo_full, fifo_empty;
    logic             back_busy;
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;

    clt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_busy      (back_busy || !fifo_empty || fifo_full),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    clt_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (fifo_empty)
    );

    clt_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TOKEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    clt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (fifo_empty),
        .i_cmd        (pop_cmd),
        .o_pop        (pop),
        .o_busy       (back_busy),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

endmodule

// ===== test/tb_top.sv =====
// testbench for config_line_tokenizer: drives lines byte by byte and checks each token beat
// against a cycle-free predictor of the tokenizer; depends on clt_pkg and the block's RTL only
`timescale 1ns / 100ps

module tb_top;
    import clt_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_SHOWN      = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       tok_last;
        logic       line_last;
        logic       cut;
    } t_token_beat;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_LIMITER;
    logic [SET_W-1:0]     i_cfg_data = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata  = '0;
    logic                 i_s_tlast  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [7:0]           o_m_tdata;
    logic [USER_W-1:0]    o_m_tuser;
    logic                 o_m_tlast;

    config_line_tokenizer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // line_byte
        .i_s_tlast  (i_s_tlast),    // line_end
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // token_byte
        .o_m_tuser  (o_m_tuser),    // byte_valid, token_last, token_truncated
        .o_m_tlast  (o_m_tlast)     // line_last
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [SET_W-1:0] lim_set = LIMITER_RESET;
    logic [SET_W-1:0] sep_set = SEPARATOR_RESET;
    logic [SET_W-1:0] com_set = COMMENT_RESET;
    logic [SET_W-1:0] quo_set = QUOTE_RESET;
    logic [7:0]       tok_buf [MAX_TOKEN];
    int               tok_len     = 0;
    bit               quoted      = 1'b0;
    bit               lim_seen    = 1'b0;
    bit               line_done   = 1'b0;
    bit               tok_cut     = 1'b0;

    t_token_beat      line_beats[$];
    t_token_beat      pending_beats[$];
    logic [7:0]       line_buf[$];

    int               mismatches  = 0;
    int               sent_count  = 0;
    int               idle_cycles = 0;
    bit               quiet       = 1'b0;
    t_out_user        got_user;

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic bit matches_set(input logic [SET_W-1:0] set, input logic [7:0] b);
        for (int k = 0; k < SET_SLOTS; k++) begin
            if (b != CH_NUL && set[8*k +: 8] == b) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // append one byte to the line being built
    function automatic void add_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endfunction

    task automatic flush_token(input bit lower);
        logic [7:0]  c;
        t_token_beat beat;
        for (int i = 0; i < tok_len; i++) begin
            c = tok_buf[i];
            if (lower && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                c = c + CASE_DELTA;
            end
            beat.data      = c;
            beat.valid     = 1'b1;
            beat.tok_last  = (i + 1 == tok_len);
            beat.line_last = 1'b0;
            beat.cut       = tok_cut;
            line_beats.insert(line_beats.size(), beat);
        end
        tok_len = 0;
        tok_cut = 1'b0;
    endtask

    // works out the beats that one accepted line byte causes
    task automatic tokenize_byte(input logic [7:0] b, input bit eol);
        t_token_beat tail;
        line_beats.delete();
        if (!line_done) begin
            if (matches_set(com_set, b)) begin
                flush_token(1'b0);
                line_done = 1'b1;
            end else if (matches_set(lim_set, b) && !lim_seen) begin
                // a limiter with nothing before it ends the line
                if (tok_len != 0) begin
                    flush_token(1'b1);
                    lim_seen = 1'b1;
                end else begin
                    line_done = 1'b1;
                end
            end else if (matches_set(sep_set, b) && !quoted) begin
                flush_token(1'b0);
            end else if (matches_set(quo_set, b)) begin
                flush_token(1'b0);
                quoted = !quoted;
            end else if ((b == CH_SPACE || b == CH_TAB) && !quoted) begin
                // blanks outside quotes vanish without splitting
            end else if (tok_len < MAX_TOKEN) begin
                tok_buf[tok_len] = b;
                tok_len++;
            end else begin
                tok_cut = 1'b1;
            end
        end
        if (eol) begin
            flush_token(1'b0);
            if (line_beats.size() == 0) begin
                line_beats.insert(0, t_token_beat'('0));
            end
            tail = line_beats[line_beats.size()-1];
            tail.line_last = 1'b1;
            line_beats[line_beats.size()-1] = tail;
            quoted    = 1'b0;
            lim_seen  = 1'b0;
            line_done = 1'b0;
        end
        foreach (line_beats[i]) begin
            pending_beats.insert(pending_beats.size(), line_beats[i]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit eol);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eol;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        tokenize_byte(b, eol);
        sent_count++;
    endtask

    task automatic send_line_buf();
        foreach (line_buf[i]) begin
            send_byte(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    // stop sending and wait until every predicted beat has come out
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [SET_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_LIMITER:   lim_set = v;
            CFG_SEPARATOR: sep_set = v;
            CFG_COMMENT:   com_set = v;
            CFG_QUOTE:     quo_set = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_sets(input logic [SET_W-1:0] lim, input logic [SET_W-1:0] sep,
                             input logic [SET_W-1:0] com, input logic [SET_W-1:0] quo);
        put_reg(CFG_LIMITER, lim);
        put_reg(CFG_SEPARATOR, sep);
        put_reg(CFG_COMMENT, com);
        put_reg(CFG_QUOTE, quo);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 2))
            0:       return CH_UPPER_A + 8'($urandom_range(0, 25));
            1:       return CH_UPPER_A + CASE_DELTA + 8'($urandom_range(0, 25));
            default: return 8'h30 + 8'($urandom_range(0, 9));    // digit
        endcase
    endfunction

    function automatic logic [7:0] blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    // random member of a set, or a plain character when the set is empty
    function automatic logic [7:0] pick_lane(input logic [SET_W-1:0] set);
        logic [7:0] lanes[$];
        for (int k = 0; k < SET_SLOTS; k++) begin
            if (set[8*k +: 8] != CH_NUL) begin
                lanes.insert(lanes.size(), set[8*k +: 8]);
            end
        end
        if (lanes.size() == 0) begin
            return word_char();
        end
        return lanes[$urandom_range(0, lanes.size() - 1)];
    endfunction

    // name, limiter, values split by separators, some quoted, maybe a trailing comment
    task automatic build_entry();
        int n;
        line_buf.delete();
        n = $urandom_range(1, 6);
        repeat (n) begin
            add_byte(word_char());
            if ($urandom_range(0, 4) == 0) begin
                add_byte(blank());
            end
        end
        add_byte(pick_lane(lim_set));
        n = $urandom_range(1, 3);
        for (int v = 0; v < n; v++) begin
            if (v > 0) begin
                add_byte(pick_lane(sep_set));
            end
            if ($urandom_range(0, 2) == 0) begin
                add_byte(pick_lane(quo_set));
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 5))
                        0:       add_byte(pick_lane(sep_set));
                        1:       add_byte(blank());
                        default: add_byte(word_char());
                    endcase
                end
                // now and then the quote is left open
                if ($urandom_range(0, 7) != 0) begin
                    add_byte(pick_lane(quo_set));
                end
            end else begin
                repeat ($urandom_range(1, 6)) add_byte(word_char());
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            add_byte(blank());
            add_byte(pick_lane(com_set));
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_noise();
        line_buf.delete();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 6))
                0:       add_byte(pick_lane(lim_set));
                1:       add_byte(pick_lane(sep_set));
                2:       add_byte(pick_lane(com_set));
                3:       add_byte(pick_lane(quo_set));
                4:       add_byte(blank());
                5:       add_byte(word_char());
                default: add_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic build_overlong();
        line_buf.delete();
        repeat ($urandom_range(MAX_TOKEN + 1, MAX_TOKEN + 4)) add_byte(word_char());
        if ($urandom_range(0, 1)) begin
            add_byte(pick_lane(lim_set));
            add_byte(word_char());
        end
    endtask

    task automatic run_random_lines(input int target);
        int first;
        first = sent_count;
        while (sent_count - first < target) begin
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 11))
                0:       build_overlong();
                1, 2, 3: build_noise();
                default: build_entry();
            endcase
            send_line_buf();
        end
        quiet = 1'b0;
    endtask

    task automatic test_directed();
        send_text("A\tb =c=d");           // name lowercased, second limiter kept as data
        send_text("=x");                  // leading limiter ends the line, bare marker
        send_text("\"a, b\"#q");          // quoted separator and space kept, comment ends line
        send_text("\"a#");                // comment inside an open quote
        send_text("a,b");                 // plain separator
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NUL, 1'b1);          // zero byte is ordinary data
        settle();
    endtask

    task automatic test_overlong();
        line_buf.delete();
        repeat (MAX_TOKEN + 2) add_byte(CH_UPPER_A + 8'($urandom_range(0, 25)));
        add_byte(pick_lane(lim_set));
        add_byte(word_char());
        send_line_buf();
        settle();
    endtask

    task automatic test_set_variants();
        load_sets(LIMITER_RESET, SEPARATOR_RESET, COMMENT_RESET, QUOTE_RESET);
        run_random_lines(4);
        settle();
        // several codes per set, tab as a separator
        load_sets(32'h0000_3A3D, 32'h097C_3B2C, 32'h0000_2F23, 32'h0000_2722);
        run_random_lines(4);
        settle();
        // shared codes: priority order decides, space becomes a separator
        load_sets(32'h0000_2C3D, 32'h0000_203B, 32'h0000_003B, 32'h0000_233D);
        run_random_lines(4);
        settle();
        // no special bytes at all
        load_sets(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        run_random_lines(4);
        settle();
        load_sets(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random_lines(4);
        settle();
        // codes in the top lane only
        load_sets(32'h3D00_0000, 32'h2C00_0000, 32'h2300_0000, 32'h2200_0000);
        run_random_lines(4);
        settle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overlong();
        test_set_variants();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // result side stalls
    initial begin
        forever begin
            int stall;
            stall = draw_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    task automatic report_beat(input string what, input t_token_beat want);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("%0t: %s: expected data %02h valid %b tok_last %b line_last %b cut %b",
                     $realtime, what, want.data, want.valid, want.tok_last, want.line_last,
                     want.cut);
            $display("    got data %02h valid %b tok_last %b line_last %b cut %b",
                     o_m_tdata, got_user.byte_valid, got_user.token_last, o_m_tlast,
                     got_user.truncated);
        end
    endtask

    // compare each output beat with the oldest predicted one
    always @(posedge i_clk) begin
        t_token_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_user = t_out_user'(o_m_tuser);
            if (pending_beats.size() == 0) begin
                report_beat("unexpected beat", '0);
            end else begin
                want = pending_beats.pop_front();
                if (o_m_tdata !== want.data || got_user.byte_valid !== want.valid ||
                    got_user.token_last !== want.tok_last || o_m_tlast !== want.line_last ||
                    got_user.truncated !== want.cut) begin
                    report_beat("beat mismatch", want);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
